// ===== hdl/tcd_pkg.sv =====
// shared types, codes and sizes for the texture column drawer
`default_nettype none
package tcd_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int TEXTURE_ROWS  = 128;
    localparam int FRACTION_BITS = 16;
    localparam int TEX_IDX_W     = $clog2(TEXTURE_ROWS);
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_DATA_W    = 9;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    localparam logic [1:0] SEL_COLORMAP    = 2'd0;
    localparam logic [1:0] SEL_TRANSLATION = 2'd1;
    localparam logic [1:0] SEL_TINT        = 2'd2;
    localparam logic [1:0] SEL_TEXTURE     = 2'd3;

    localparam logic [2:0] MODE_PLAIN      = 3'd0;
    localparam logic [2:0] MODE_TINT       = 3'd1;
    localparam logic [2:0] MODE_ALT_TINT   = 3'd2;
    localparam logic [2:0] MODE_TRANS      = 3'd3;
    localparam logic [2:0] MODE_TRANS_TINT = 3'd4;

    localparam logic [1:0] CFG_CENTER_ROW    = 2'd0;
    localparam logic [1:0] CFG_VIEW_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_VIEW_X_OFFSET = 2'd2;
    localparam logic [1:0] CFG_VIEW_Y_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_PIXEL
    } op_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         table_select;
        logic [15:0]        table_index;
        logic [7:0]         table_value;
        logic [7:0]         first_row;
        logic [7:0]         last_row;
        logic [8:0]         screen_column;
        logic signed [31:0] step;
        logic signed [31:0] texture_mid;
        logic [2:0]         mode;
        logic [7:0]         under_pixel;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
        logic [7:0]  pixel_count;
        logic        last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [7:0] center_row;
        logic [7:0] view_height;
        logic [8:0] view_x_offset;
        logic [7:0] view_y_offset;
    } cfg_t;

    // one classified item between front and back
    typedef struct packed {
        op_t                  kind;
        logic [1:0]           sel;
        logic [15:0]          index;
        logic [7:0]           value;
        logic [TEX_IDX_W-1:0] texel;
        logic [7:0]           row;
        logic [8:0]           column;
        logic [2:0]           mode;
        logic [7:0]           under;
        logic [7:0]           count;
        logic                 last;
    } q_entry_t;

endpackage
`default_nettype wire

// ===== hdl/tcd_front.sv =====
// front end: takes items, sets up columns, steps the coordinate, classifies
`default_nettype none
module tcd_front
    import tcd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire cfg_t     cfg,
    output logic          q_push,
    output q_entry_t      q_data,
    input  wire logic     q_ready
);

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  sel;
        logic [15:0] index;
        logic [7:0]  value;
        logic [2:0]  mode;
        logic [7:0]  first;
        logic [7:0]  cnt;
        logic [8:0]  column;
        logic [31:0] step;
        logic [31:0] mid;
        logic [31:0] prod;
        logic [7:0]  under;
    } s1_t;

    logic        s1_valid_reg, s1_valid_next;
    s1_t         s1_reg, s1_next;
    logic        s1_fire;
    logic        do_push;

    logic [31:0] coord_reg, coord_next;
    logic [31:0] step_reg, step_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  left_reg, left_next;
    logic [8:0]  column_reg, column_next;
    logic [2:0]  mode_reg, mode_next;

    logic [2:0]         mode_n;
    logic               clip;
    logic signed [9:0]  first_c, last_c, cnt_s, diff;
    logic [7:0]         cnt;

    // start setup: mode cleanup, translucent clipping, row count, offset product
    always_comb
    begin
        mode_n  = (in_data.mode > MODE_TRANS_TINT) ? MODE_PLAIN : in_data.mode;
        clip    = (mode_n == MODE_TINT) || (mode_n == MODE_ALT_TINT);
        first_c = {2'b00, in_data.first_row};
        last_c  = {2'b00, in_data.last_row};
        if (clip && in_data.first_row == 8'd0)
        begin
            first_c = 10'sd1;
        end
        if (clip && last_c == ({2'b00, cfg.view_height} - 10'sd1))
        begin
            last_c = {2'b00, cfg.view_height} - 10'sd2;
        end
        cnt_s = last_c - first_c + 10'sd1;
        if (cnt_s < 10'sd0)
        begin
            cnt = 8'd0;
        end
        else if (cnt_s > 10'sd255)
        begin
            cnt = 8'd255;
        end
        else
        begin
            cnt = cnt_s[7:0];
        end
        diff = first_c - {2'b00, cfg.center_row};

        s1_next.func   = in_data.func;
        s1_next.sel    = in_data.table_select;
        s1_next.index  = in_data.table_index;
        s1_next.value  = in_data.table_value;
        s1_next.mode   = mode_n;
        s1_next.first  = first_c[7:0];
        s1_next.cnt    = cnt;
        s1_next.column = in_data.screen_column;
        s1_next.step   = in_data.step;
        s1_next.mid    = in_data.texture_mid;
        s1_next.prod   = 32'(diff * in_data.step);
        s1_next.under  = in_data.under_pixel;
    end

    assign in_ready      = !s1_valid_reg || q_ready;
    assign s1_fire       = s1_valid_reg && q_ready;
    assign s1_valid_next = (in_valid && in_ready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    // second stage: column state update and queue entry
    always_comb
    begin
        q_data        = '0;
        q_data.kind   = OP_LOAD;
        q_data.sel    = s1_reg.sel;
        q_data.index  = s1_reg.index;
        q_data.value  = s1_reg.value;
        q_data.texel  = TEX_IDX_W'($signed(coord_reg) >>> FRACTION_BITS);
        q_data.row    = row_reg;
        q_data.column = column_reg;
        q_data.mode   = mode_reg;
        q_data.under  = s1_reg.under;
        do_push       = 1'b0;
        coord_next    = coord_reg;
        step_next     = step_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        column_next   = column_reg;
        mode_next     = mode_reg;
        unique case (s1_reg.func)
            FUNC_LOAD:
            begin
                do_push = 1'b1;
            end
            FUNC_START:
            begin
                do_push      = 1'b1;
                q_data.kind  = OP_START;
                q_data.count = s1_reg.cnt;
                coord_next   = s1_reg.mid + s1_reg.prod;
                step_next    = s1_reg.step;
                row_next     = s1_reg.first;
                left_next    = s1_reg.cnt;
                column_next  = s1_reg.column;
                mode_next    = s1_reg.mode;
            end
            FUNC_PIXEL:
            begin
                if (left_reg != 8'd0)
                begin
                    do_push     = 1'b1;
                    q_data.kind = OP_PIXEL;
                    q_data.last = (left_reg == 8'd1);
                    coord_next  = coord_reg + step_reg;
                    row_next    = row_reg + 8'd1;
                    left_next   = left_reg - 8'd1;
                end
            end
            default:
            begin
                do_push = 1'b0;
            end
        endcase
    end

    assign q_push = s1_fire && do_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            coord_reg    <= '0;
            step_reg     <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            column_reg   <= '0;
            mode_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                coord_reg  <= coord_next;
                step_reg   <= step_next;
                row_reg    <= row_next;
                left_reg   <= left_next;
                column_reg <= column_next;
                mode_reg   <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_reg.func == FUNC_START) |=> (left_reg == $past(s1_reg.cnt)))
        else $error("column start did not load the pixel count");

    a_no_pixel_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_data.kind == OP_PIXEL) |-> (left_reg != 8'd0))
        else $error("pixel item queued with no column active");

endmodule
`default_nettype wire

// ===== hdl/tcd_queue.sv =====
// short item queue between front end and back end
`default_nettype none
module tcd_queue
    import tcd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    output logic          ready,
    output logic          valid,
    output q_entry_t      head,
    input  wire logic     pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== hdl/tcd_back.sv =====
// back end: table loads and the texel lookup pipeline down to the result register
`default_nettype none
module tcd_back
    import tcd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     q_valid,
    input  wire q_entry_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    typedef struct packed {
        op_t         kind;
        logic [1:0]  sel;
        logic [15:0] index;
        logic [7:0]  value;
        logic [2:0]  mode;
        logic [7:0]  under;
        logic [7:0]  count;
        logic        last;
        logic [15:0] addr;
    } bk_t;

    logic en;
    bk_t  b0, b1_reg, b2_reg, b3_reg, b4_reg;
    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, out_valid_reg;

    logic [7:0] tex_mem   [TEXTURE_ROWS];
    logic [7:0] trans_mem [256];
    logic [7:0] cmap_mem  [256];
    logic [7:0] tint_mem  [65536];

    logic [7:0]  tex_rd_reg, trans_rd_reg, cmap_rd_reg, tint_rd_reg;
    logic [7:0]  b2_tex_reg, b4_shade_reg;
    logic [7:0]  cmap_addr;
    logic [15:0] tint_addr;
    logic        b4_pixel, b4_tinted;

    // whole pipeline moves together, held only by a waiting result
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        b0.kind  = q_data.kind;
        b0.sel   = q_data.sel;
        b0.index = q_data.index;
        b0.value = q_data.value;
        b0.mode  = q_data.mode;
        b0.under = q_data.under;
        b0.count = q_data.count;
        b0.last  = q_data.last;
        b0.addr  = '0;
        if (q_data.kind == OP_PIXEL)
        begin
            b0.addr = 16'((16'(cfg.view_y_offset) + 16'(q_data.row)) * 16'(SCREEN_WIDTH))
                    + 16'(cfg.view_x_offset) + 16'(q_data.column);
        end
    end

    // loads write each table at the stage that reads it, so order is kept
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_valid && q_data.kind == OP_LOAD && q_data.sel == SEL_TEXTURE)
            begin
                tex_mem[q_data.index[TEX_IDX_W-1:0]] <= q_data.value;
            end
            tex_rd_reg <= tex_mem[q_data.texel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b1_valid_reg && b1_reg.kind == OP_LOAD && b1_reg.sel == SEL_TRANSLATION)
            begin
                trans_mem[b1_reg.index[7:0]] <= b1_reg.value;
            end
            trans_rd_reg <= trans_mem[tex_rd_reg];
        end
    end

    assign cmap_addr = (b2_reg.mode == MODE_TRANS || b2_reg.mode == MODE_TRANS_TINT)
                     ? trans_rd_reg : b2_tex_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b2_valid_reg && b2_reg.kind == OP_LOAD && b2_reg.sel == SEL_COLORMAP)
            begin
                cmap_mem[b2_reg.index[7:0]] <= b2_reg.value;
            end
            cmap_rd_reg <= cmap_mem[cmap_addr];
        end
    end

    // tint mode puts the shade in the high byte, the other tinted modes the under pixel
    assign tint_addr = (b3_reg.mode == MODE_TINT) ? {cmap_rd_reg, b3_reg.under}
                                                  : {b3_reg.under, cmap_rd_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b3_valid_reg && b3_reg.kind == OP_LOAD && b3_reg.sel == SEL_TINT)
            begin
                tint_mem[b3_reg.index] <= b3_reg.value;
            end
            tint_rd_reg <= tint_mem[tint_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg       <= b0;
            b2_reg       <= b1_reg;
            b2_tex_reg   <= tex_rd_reg;
            b3_reg       <= b2_reg;
            b4_reg       <= b3_reg;
            b4_shade_reg <= cmap_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg && (b3_reg.kind != OP_LOAD);
        end
    end

    assign b4_pixel  = (b4_reg.kind == OP_PIXEL);
    assign b4_tinted = (b4_reg.mode == MODE_TINT) || (b4_reg.mode == MODE_ALT_TINT)
                    || (b4_reg.mode == MODE_TRANS_TINT);

    always_comb
    begin
        out_data.result_kind   = b4_pixel;
        out_data.pixel_address = b4_reg.addr;
        out_data.pixel_value   = b4_pixel ? (b4_tinted ? tint_rd_reg : b4_shade_reg) : 8'd0;
        out_data.pixel_count   = b4_pixel ? 8'd0 : b4_reg.count;
        out_data.last_pixel    = b4_pixel && b4_reg.last;
    end

    assign out_valid = out_valid_reg;

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && b3_valid_reg && b3_reg.kind == OP_LOAD) |=> !out_valid_reg)
        else $error("table load produced a result item");

    a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.result_kind) |-> (out_data.pixel_address == 16'd0))
        else $error("start result carries a pixel address");

endmodule
`default_nettype wire

// ===== hdl/texture_column_drawer.sv =====
// texture column drawer top level: configuration registers, front end, queue, back end
// path: a taken item is registered in the front stage, held in the queue, then read through the back end stages
// throughput: one item per cycle, loads, starts and pixels alike, while the output is not held off
// a start spends one front stage on the row offset times step product
// a pixel goes through four table reads (texture, translation, colormap, tint)
// reset: column state cleared, registers to 100/200/0/0, tables hold nothing until loaded
`default_nettype none
module texture_column_drawer
    import tcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     q_push, q_ready, q_valid, q_pop;
    q_entry_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_row    <= 8'd100;
            cfg_reg.view_height   <= 8'd200;
            cfg_reg.view_x_offset <= 9'd0;
            cfg_reg.view_y_offset <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_ROW:    cfg_reg.center_row    <= cfg_data[7:0];
                CFG_VIEW_HEIGHT:   cfg_reg.view_height   <= cfg_data[7:0];
                CFG_VIEW_X_OFFSET: cfg_reg.view_x_offset <= cfg_data[8:0];
                CFG_VIEW_Y_OFFSET: cfg_reg.view_y_offset <= cfg_data[7:0];
                default:           cfg_reg.center_row    <= cfg_reg.center_row;
            endcase
        end
    end

    tcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_ready  (q_ready)
    );

    tcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    tcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== dv/texture_column_drawer_tb.sv =====
// texture column drawer testbench: predicted starts and frame buffer writes checked on the output
`default_nettype none
module texture_column_drawer_tb;
    import tcd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED       = 2'd3;
    localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;
    localparam logic       KIND_COLUMN       = 1'b0;
    localparam logic       KIND_WRITE        = 1'b1;

    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int QUIET_CYCLES = 12;
    localparam int MAX_REPORTS  = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted drawer state
    cfg_t       regs = '{8'd100, 8'd200, 9'd0, 8'd0};
    logic [7:0] tex_bytes [TEXTURE_ROWS];
    bit         tex_loaded [TEXTURE_ROWS];
    logic [7:0] shade_bytes [256];
    bit         shade_loaded [256];
    logic [7:0] remap_bytes [256];
    bit         remap_loaded [256];
    logic [7:0] blend_bytes [65536];
    bit         blend_loaded [65536];
    logic [31:0] coord      = '0;
    logic [31:0] coord_step = '0;
    logic [7:0]  row_at     = '0;
    logic [7:0]  rows_left  = '0;
    logic [8:0]  col_at     = '0;
    logic [2:0]  mode_at    = MODE_PLAIN;

    out_item_t expected_writes [$];
    out_item_t head_write;
    int        errors = 0;
    int        sent_items = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        steady = 1'b0;

    texture_column_drawer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random idling, plus a counted hold-off when requested
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 12);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_writes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: expected none got %h",
                             $time, out_data);
            end
            else
            begin
                head_write = expected_writes.pop_front();
                check_field("result_kind", 16'(head_write.result_kind), 16'(out_data.result_kind));
                check_field("pixel_address", head_write.pixel_address, out_data.pixel_address);
                check_field("pixel_value", 16'(head_write.pixel_value), 16'(out_data.pixel_value));
                check_field("pixel_count", 16'(head_write.pixel_count), 16'(out_data.pixel_count));
                check_field("last_pixel", 16'(head_write.last_pixel), 16'(out_data.last_pixel));
            end
        end
    end

    function automatic logic [TEX_IDX_W-1:0] tex_slot(input logic [31:0] c);
        logic signed [31:0] whole;
        whole = $signed(c) >>> FRACTION_BITS;
        return whole[TEX_IDX_W-1:0];
    endfunction

    function automatic bit is_tint(input logic [2:0] m);
        return m == MODE_TINT || m == MODE_ALT_TINT || m == MODE_TRANS_TINT;
    endfunction

    // tint mode puts the shade in the high byte, the other two the underlying pixel
    function automatic logic [15:0] blend_slot(input logic [2:0] m, input logic [7:0] shade,
                                               input logic [7:0] under);
        return (m == MODE_TINT) ? {shade, under} : {under, shade};
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.center_row    = 8'($urandom_range(0, 199));
        c.view_height   = 8'($urandom_range(1, 200));
        c.view_x_offset = 9'($urandom_range(0, 319));
        c.view_y_offset = 8'($urandom_range(0, 199));
        return c;
    endfunction

    // updates the predicted state for one accepted item and queues its result, if it has one
    task automatic advance_drawer(input in_item_t it);
        int top_row;
        int bottom_row;
        int span;
        logic [2:0] m;
        logic [7:0] texel;
        logic [7:0] shade;
        out_item_t w;
        w = '0;
        case (it.func)
            FUNC_LOAD:
                case (it.table_select)
                    SEL_COLORMAP:
                    begin
                        shade_bytes[it.table_index[7:0]] = it.table_value;
                        shade_loaded[it.table_index[7:0]] = 1'b1;
                    end
                    SEL_TRANSLATION:
                    begin
                        remap_bytes[it.table_index[7:0]] = it.table_value;
                        remap_loaded[it.table_index[7:0]] = 1'b1;
                    end
                    SEL_TINT:
                    begin
                        blend_bytes[it.table_index] = it.table_value;
                        blend_loaded[it.table_index] = 1'b1;
                    end
                    default:
                    begin
                        tex_bytes[it.table_index[TEX_IDX_W-1:0]] = it.table_value;
                        tex_loaded[it.table_index[TEX_IDX_W-1:0]] = 1'b1;
                    end
                endcase
            FUNC_START:
            begin
                m = (it.mode > MODE_TRANS_TINT) ? MODE_PLAIN : it.mode;
                top_row = it.first_row;
                bottom_row = it.last_row;
                // translucent columns stay off the top row and the last view row
                if (m == MODE_TINT || m == MODE_ALT_TINT)
                begin
                    if (top_row == 0)
                        top_row = 1;
                    if (bottom_row == int'(regs.view_height) - 1)
                        bottom_row = int'(regs.view_height) - 2;
                end
                span = bottom_row - top_row + 1;
                if (span < 0)
                    span = 0;
                if (span > 255)
                    span = 255;
                coord_step = it.step;
                coord = it.texture_mid + (top_row - int'(regs.center_row)) * it.step;
                row_at = 8'(top_row);
                rows_left = 8'(span);
                col_at = it.screen_column;
                mode_at = m;
                w.result_kind = KIND_COLUMN;
                w.pixel_count = 8'(span);
                expected_writes.push_back(w);
            end
            FUNC_PIXEL:
                if (rows_left != 0)
                begin
                    texel = tex_bytes[tex_slot(coord)];
                    if (mode_at == MODE_TRANS || mode_at == MODE_TRANS_TINT)
                        texel = remap_bytes[texel];
                    shade = shade_bytes[texel];
                    w.result_kind = KIND_WRITE;
                    w.pixel_value = is_tint(mode_at)
                        ? blend_bytes[blend_slot(mode_at, shade, it.under_pixel)] : shade;
                    w.pixel_address = 16'((int'(regs.view_y_offset) + int'(row_at)) * SCREEN_WIDTH
                                          + int'(regs.view_x_offset) + int'(col_at));
                    w.last_pixel = (rows_left == 8'd1);
                    expected_writes.push_back(w);
                    coord += coord_step;
                    row_at += 8'd1;
                    rows_left -= 8'd1;
                end
            default: ;
        endcase
    endtask

    task automatic send_item(input in_item_t it);
        if (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_drawer(it);
        sent_items++;
    endtask

    task automatic load_entry(input logic [1:0] sel, input logic [15:0] index,
                              input logic [7:0] value);
        in_item_t it;
        it = noise_item();
        it.func = FUNC_LOAD;
        it.table_select = sel;
        it.table_index = index;
        it.table_value = value;
        send_item(it);
    endtask

    task automatic start_column(input logic [7:0] top_row, input logic [7:0] bottom_row,
                                input logic [8:0] column, input logic signed [31:0] stp,
                                input logic signed [31:0] mid, input logic [2:0] m);
        in_item_t it;
        it = noise_item();
        it.func = FUNC_START;
        it.first_row = top_row;
        it.last_row = bottom_row;
        it.screen_column = column;
        it.step = stp;
        it.texture_mid = mid;
        it.mode = m;
        send_item(it);
    endtask

    // loads whatever table entries the next pixel will read that were never written
    task automatic prime_pixel(input logic [7:0] under);
        logic [TEX_IDX_W-1:0] slot;
        logic [7:0]  texel;
        logic [7:0]  shade;
        logic [15:0] index;
        if (rows_left == 0)
            return;
        slot = tex_slot(coord);
        if (!tex_loaded[slot])
        begin
            index = 16'($urandom);
            index[TEX_IDX_W-1:0] = slot;
            load_entry(SEL_TEXTURE, index, 8'($urandom));
        end
        texel = tex_bytes[slot];
        if (mode_at == MODE_TRANS || mode_at == MODE_TRANS_TINT)
        begin
            if (!remap_loaded[texel])
            begin
                index = 16'($urandom);
                index[7:0] = texel;
                load_entry(SEL_TRANSLATION, index, 8'($urandom));
            end
            texel = remap_bytes[texel];
        end
        if (!shade_loaded[texel])
        begin
            index = 16'($urandom);
            index[7:0] = texel;
            load_entry(SEL_COLORMAP, index, 8'($urandom));
        end
        shade = shade_bytes[texel];
        if (is_tint(mode_at) && !blend_loaded[blend_slot(mode_at, shade, under)])
            load_entry(SEL_TINT, blend_slot(mode_at, shade, under), 8'($urandom));
    endtask

    task automatic draw_pixel(input logic [7:0] under);
        in_item_t it;
        prime_pixel(under);
        it = noise_item();
        it.func = FUNC_PIXEL;
        it.under_pixel = under;
        send_item(it);
    endtask

    task automatic send_unused_func();
        in_item_t it;
        it = noise_item();
        it.func = FUNC_UNUSED;
        send_item(it);
    endtask

    // waits for every expected result, then lets the pipeline run dry
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_writes.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_writes.size());
            expected_writes.delete();
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CENTER_ROW;
        cfg_data <= 9'(c.center_row);
        @(posedge clk);
        cfg_index <= CFG_VIEW_HEIGHT;
        cfg_data <= 9'(c.view_height);
        @(posedge clk);
        cfg_index <= CFG_VIEW_X_OFFSET;
        cfg_data <= c.view_x_offset;
        @(posedge clk);
        cfg_index <= CFG_VIEW_Y_OFFSET;
        cfg_data <= 9'(c.view_y_offset);
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = c;
    endtask

    task automatic random_column();
        int top_row;
        int bottom_row;
        int len;
        int n;
        logic [2:0] m;
        logic signed [31:0] stp;
        if ($urandom_range(99) < 3)
            m = 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        else
            m = 3'($urandom_range(MODE_PLAIN, MODE_TRANS_TINT));
        top_row = $urandom_range(0, 199);
        len = ($urandom_range(9) == 0) ? $urandom_range(0, 199) : $urandom_range(0, 24);
        bottom_row = (top_row + len > 199) ? 199 : top_row + len;
        if ($urandom_range(9) == 0)
            bottom_row = $urandom_range(0, 199);
        // aim at the translucent clip rows now and then
        if ($urandom_range(4) == 0)
            top_row = 0;
        if ($urandom_range(4) == 0)
            bottom_row = int'(regs.view_height) - 1;
        stp = $urandom;
        if ($urandom_range(1) == 0)
            stp = stp >>> 13;
        start_column(8'(top_row), 8'(bottom_row), 9'($urandom_range(0, 319)), stp,
                     $urandom, m);
        n = rows_left;
        if ($urandom_range(9) == 0)
            n = $urandom_range(0, n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                load_entry(2'($urandom), 16'($urandom), 8'($urandom));
            draw_pixel(8'($urandom));
        end
        if ($urandom_range(14) == 0)
            draw_pixel(8'($urandom));
        if ($urandom_range(24) == 0)
            send_unused_func();
    endtask

    task automatic test_table_loads();
        load_entry(SEL_COLORMAP, 16'hFFFF, 8'hFF);
        load_entry(SEL_TRANSLATION, 16'h0000, 8'h00);
        load_entry(SEL_TINT, 16'hFFFF, 8'hA5);
        load_entry(SEL_TEXTURE, 16'hFFFF, 8'h5A);
        load_entry(SEL_TEXTURE, 16'h0000, 8'hFF);
    endtask

    task automatic test_draw_modes();
        start_column(8'd198, 8'd199, 9'd319, 32'sh7FFF_FFFF, 32'sh8000_0000, MODE_PLAIN);
        draw_pixel(8'h00);
        draw_pixel(8'hFF);
        start_column(8'd0, 8'd199, 9'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, MODE_TINT);
        draw_pixel(8'hFF);
        draw_pixel(8'h00);
        start_column(8'd0, 8'd199, 9'd160, 32'sh0001_0000, 32'sh0000_0000, MODE_ALT_TINT);
        draw_pixel(8'h5A);
        draw_pixel(8'hA5);
        start_column(8'd50, 8'd52, 9'd1, -32'sh0000_8000, 32'sh0040_0000, MODE_TRANS);
        draw_pixel(8'h01);
        draw_pixel(8'h80);
        start_column(8'd100, 8'd101, 9'd200, 32'sh0002_0000, -32'sh0010_0000, MODE_TRANS_TINT);
        draw_pixel(8'hFE);
        draw_pixel(8'h7F);
        start_column(8'd5, 8'd6, 9'd7, 32'sh0001_0000, 32'sh0000_0000, MODE_LAST_UNUSED);
        draw_pixel(8'h33);
    endtask

    task automatic test_special_columns();
        // empty column, then a pixel with nothing active
        start_column(8'd10, 8'd5, 9'd33, 32'sh0001_0000, 32'sh0000_0000, MODE_PLAIN);
        draw_pixel(8'hC3);
        send_unused_func();
        // long column saturates its count, then is replaced mid-way
        start_column(8'd0, 8'd255, 9'd77, 32'sh0000_4000, 32'sh0012_3456, MODE_FIRST_UNUSED);
        draw_pixel(8'h11);
        draw_pixel(8'h22);
        start_column(8'd20, 8'd21, 9'd78, -32'sh0003_0000, 32'sh0000_0000, MODE_PLAIN);
        draw_pixel(8'h44);
        draw_pixel(8'h88);
    endtask

    // output held off while the input keeps offering pixels
    task automatic test_output_stall();
        settle();
        start_column(8'd0, 8'd199, 9'd12, 32'sh0000_A000, 32'sh0003_0000, MODE_TRANS_TINT);
        stall_left = 400;
        repeat (150) draw_pixel(8'($urandom));
    endtask

    task automatic test_register_sweep();
        cfg_t plan [4];
        plan[0] = '{8'd0, 8'd1, 9'd0, 8'd0};
        plan[1] = '{8'd199, 8'd200, 9'd319, 8'd199};
        plan[2] = random_setting();
        plan[3] = random_setting();
        foreach (plan[k])
        begin
            settle();
            write_regs(plan[k]);
            repeat (8) random_column();
        end
    endtask

    task automatic test_random_stream();
        int columns;
        columns = 0;
        while (sent_items < ITEM_TARGET || columns < 10)
        begin
            // a stretch of columns with no idling on either side
            steady = (columns >= 2 && columns < 8);
            random_column();
            columns++;
            if (columns % 40 == 0)
            begin
                settle();
                write_regs(random_setting());
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CENTER_ROW;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_loads();
        test_draw_modes();
        test_special_columns();
        test_output_stall();
        test_register_sweep();
        test_random_stream();
        settle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
